>>> rtl/ebkps_pkg.sv
package ebkps_pkg;

    localparam int STAT_W  = 32;
    localparam int ID_W    = 6;
    localparam int CNT_W   = 7;
    localparam int RATIO_W = 16;
    localparam int FAULT_W = 2;
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 4;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_EXPERT_TOTAL = 2'd0;
    localparam logic [1:0] REG_ROUTER_TOP_K = 2'd1;
    localparam logic [1:0] REG_PRUNE_RATIO  = 2'd2;

    localparam logic [FAULT_W-1:0] FAULT_NONE       = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_ZERO_PRUNE = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_MISMATCH   = 2'd2;

    localparam logic [CNT_W-1:0] EXPERT_TOTAL_RST = 7'd64;
    localparam logic [CNT_W-1:0] ROUTER_TOP_K_RST = 7'd8;
    localparam logic [CNT_W-1:0] COUNT_SAT        = 7'd127;

    typedef struct packed {
        logic [STAT_W-1:0] weighted_sum;
        logic [STAT_W-1:0] hit_count;
        logic              final_expert;
    } stat_word_t;

    typedef struct packed {
        logic [ID_W-1:0]    disabled_id;
        logic               run_end;
        logic [FAULT_W-1:0] fault;
    } pick_word_t;

    // statistics travelling round the ring of cells
    typedef struct packed {
        logic [STAT_W-1:0] num;
        logic [STAT_W-1:0] den;
        logic [ID_W-1:0]   id;
        logic              vld;
    } rot_t;

    typedef struct packed {
        logic clr;     // reset rank, take own statistics onto the ring
        logic mul_en;  // compare against travelling entry, rotate
    } cell_ctrl_t;

endpackage

>>> rtl/ebkps_cell.sv
module ebkps_cell #(
    parameter int IDX = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ebkps_pkg::cell_ctrl_t               ctrl,
    input  logic                                wr_en,
    input  logic [ebkps_pkg::STAT_W-1:0]        wr_num,
    input  logic [ebkps_pkg::STAT_W-1:0]        wr_den,
    input  logic                                own_vld,
    input  logic [ebkps_pkg::CNT_W-1:0]         prune_count,
    input  ebkps_pkg::rot_t                     rot_in,
    output ebkps_pkg::rot_t                     rot_out,
    output logic                                disable_flag
);
    import ebkps_pkg::*;

    logic [STAT_W-1:0]   num_reg;
    logic [STAT_W-1:0]   den_reg;
    rot_t                t_reg;
    logic [2*STAT_W-1:0] p_tx_reg;   // travelling num * own den
    logic [2*STAT_W-1:0] p_ox_reg;   // own num * travelling den
    logic [ID_W-1:0]     p_id_reg;
    logic                p_live_reg;
    logic                p_live_next;
    logic [CNT_W-1:0]    rank_reg;
    logic [CNT_W-1:0]    rank_next;
    logic                ahead;

    assign p_live_next = ctrl.mul_en && t_reg.vld && (t_reg.id != ID_W'(IDX));

    // travelling expert ranks ahead: strictly less important, or tie at a lower id
    assign ahead = (p_tx_reg < p_ox_reg) ||
                   ((p_tx_reg == p_ox_reg) && (p_id_reg < ID_W'(IDX)));

    always_comb
    begin
        rank_next = rank_reg;
        if (ctrl.clr)
        begin
            rank_next = '0;
        end
        else if (p_live_reg && ahead)
        begin
            rank_next = rank_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            num_reg <= wr_num;
            den_reg <= wr_den;
        end
        if (ctrl.clr)
        begin
            t_reg.num <= num_reg;
            t_reg.den <= den_reg;
            t_reg.id  <= ID_W'(IDX);
            t_reg.vld <= own_vld;
        end
        else if (ctrl.mul_en)
        begin
            t_reg <= rot_in;
        end
        if (ctrl.mul_en)
        begin
            p_tx_reg <= t_reg.num * den_reg;
            p_ox_reg <= num_reg * t_reg.den;
            p_id_reg <= t_reg.id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_live_reg <= 1'b0;
            rank_reg   <= '0;
        end
        else
        begin
            p_live_reg <= p_live_next;
            rank_reg   <= rank_next;
        end
    end

    assign rot_out      = t_reg;
    assign disable_flag = rank_reg < prune_count;

endmodule

>>> rtl/expert_bottom_k_pruning_selector.sv
// Bottom-k expert selector. Load one layer's statistics as stat words, one
// expert per word in id order, one word per cycle; final_expert marks the
// last. Each expert is held in its own cell of a ring of MAX_EXPERTS cells.
// After the final word the block checks the loaded count against
// expert_total and works out the prune count, floor(expert_total *
// prune_ratio_q16 / 65536) capped at expert_total - router_top_k. A mismatch
// gives one fault word (fault 2), a zero prune count one fault word
// (fault 1). Otherwise every cell's statistics travel once round the ring,
// one hop per cycle; each cell ranks itself by exact cross-multiplication
// against each passer-by (ties to the lower id), and the ids ranked below
// the prune count leave as pick words in ascending id order, run_end on the
// last. After the final word the block decides; for a prune it then runs
// the ring pass (start, rank, drain) and scans the cells for output in id
// order, up to expert_total cells, where an output stall holds the scan.
// stat_ready is low from the final word until the last pick word is
// in the output register; that word may still wait while the next layer
// loads. The stores have no reset and need no clearing pass. Registers:
// expert_total at 0x0, router_top_k at 0x4, prune_ratio_q16 at 0x8; write
// only while idle.
module expert_bottom_k_pruning_selector #(
    parameter int MAX_EXPERTS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ebkps_pkg::PADDR_W-1:0]       paddr,
    input  logic [ebkps_pkg::PDATA_W-1:0]       pwdata,
    output logic [ebkps_pkg::PDATA_W-1:0]       prdata,
    output logic                                pready,
    input  logic                                stat_valid,
    output logic                                stat_ready,
    input  ebkps_pkg::stat_word_t               stat_word,
    output logic                                pick_valid,
    input  logic                                pick_ready,
    output ebkps_pkg::pick_word_t               pick_word
);
    import ebkps_pkg::*;

    localparam int IDX_W = (MAX_EXPERTS > 1) ? $clog2(MAX_EXPERTS) : 1;

    typedef enum logic [2:0] {
        S_LOAD,
        S_DECIDE,
        S_REPORT,
        S_START,
        S_RANK,
        S_DRAIN,
        S_EMIT
    } state_t;

    // configuration
    logic [CNT_W-1:0]   expert_total_reg;
    logic [CNT_W-1:0]   router_top_k_reg;
    logic [RATIO_W-1:0] prune_ratio_reg;
    logic               cfg_wr;

    // control
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   loaded_reg, loaded_next;
    logic [CNT_W-1:0]   seen_reg, seen_next;       // loaded count at final word
    logic [CNT_W-1:0]   count_reg, count_next;     // prune count
    logic [FAULT_W-1:0] fault_reg, fault_next;
    logic [IDX_W-1:0]   step_reg, step_next;       // ring hop counter
    logic [IDX_W-1:0]   scan_reg, scan_next;       // output scan
    logic [CNT_W-1:0]   sent_reg, sent_next;       // pick words sent
    logic               pick_valid_reg, pick_valid_next;
    pick_word_t         pick_word_reg, pick_word_next;

    logic               stat_take;
    logic               slot_free;
    logic [CNT_W-1:0]   loaded_inc;
    logic [STAT_W-1:0]  norm_num;
    logic [STAT_W-1:0]  norm_den;
    logic [CNT_W+RATIO_W-1:0] scaled;
    logic [CNT_W-1:0]   raw_count;
    logic [CNT_W-1:0]   cap;
    logic [CNT_W-1:0]   capped;
    logic               mismatch;

    cell_ctrl_t             cell_ctrl;
    rot_t                   rot_out [MAX_EXPERTS];
    logic [MAX_EXPERTS-1:0] dis_vec;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_EXPERT_TOTAL: prdata = PDATA_W'(expert_total_reg);
            REG_ROUTER_TOP_K: prdata = PDATA_W'(router_top_k_reg);
            REG_PRUNE_RATIO:  prdata = PDATA_W'(prune_ratio_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expert_total_reg <= EXPERT_TOTAL_RST;
            router_top_k_reg <= ROUTER_TOP_K_RST;
            prune_ratio_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_EXPERT_TOTAL: expert_total_reg <= pwdata[CNT_W-1:0];
                REG_ROUTER_TOP_K: router_top_k_reg <= pwdata[CNT_W-1:0];
                REG_PRUNE_RATIO:  prune_ratio_reg  <= pwdata[RATIO_W-1:0];
                default:          ;
            endcase
        end
    end

    // ---------------- load path ----------------
    assign stat_ready = (state_reg == S_LOAD);
    assign stat_take  = stat_valid && stat_ready;
    assign loaded_inc = (loaded_reg == COUNT_SAT) ? loaded_reg : loaded_reg + CNT_W'(1);

    // zero hits means importance 0: store as 0 / 1
    assign norm_num = (stat_word.hit_count == '0) ? '0 : stat_word.weighted_sum;
    assign norm_den = (stat_word.hit_count == '0) ? STAT_W'(1) : stat_word.hit_count;

    // ---------------- decision ----------------
    assign scaled    = expert_total_reg * prune_ratio_reg;
    assign raw_count = scaled[CNT_W+RATIO_W-1:RATIO_W];
    assign cap       = (router_top_k_reg >= expert_total_reg) ? '0
                     : expert_total_reg - router_top_k_reg;
    assign capped    = (raw_count > cap) ? cap : raw_count;
    assign mismatch  = (expert_total_reg == '0) ||
                       (expert_total_reg > CNT_W'(MAX_EXPERTS)) ||
                       (seen_reg != expert_total_reg);

    assign slot_free = !pick_valid_reg || pick_ready;

    always_comb
    begin
        state_next      = state_reg;
        loaded_next     = loaded_reg;
        seen_next       = seen_reg;
        count_next      = count_reg;
        fault_next      = fault_reg;
        step_next       = step_reg;
        scan_next       = scan_reg;
        sent_next       = sent_reg;
        pick_valid_next = pick_valid_reg && !pick_ready;
        pick_word_next  = pick_word_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (stat_take)
                begin
                    if (stat_word.final_expert)
                    begin
                        seen_next   = loaded_inc;
                        loaded_next = '0;
                        state_next  = S_DECIDE;
                    end
                    else
                    begin
                        loaded_next = loaded_inc;
                    end
                end
            end
            S_DECIDE:
            begin
                count_next = capped;
                if (mismatch)
                begin
                    fault_next = FAULT_MISMATCH;
                    state_next = S_REPORT;
                end
                else if (capped == '0)
                begin
                    fault_next = FAULT_ZERO_PRUNE;
                    state_next = S_REPORT;
                end
                else
                begin
                    state_next = S_START;
                end
            end
            S_REPORT:
            begin
                if (slot_free)
                begin
                    pick_valid_next             = 1'b1;
                    pick_word_next.disabled_id  = '0;
                    pick_word_next.run_end      = 1'b1;
                    pick_word_next.fault        = fault_reg;
                    state_next                  = S_LOAD;
                end
            end
            S_START:
            begin
                step_next  = '0;
                state_next = S_RANK;
            end
            S_RANK:
            begin
                step_next = step_reg + IDX_W'(1);
                if (step_reg == IDX_W'(MAX_EXPERTS - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                scan_next  = '0;
                sent_next  = '0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (dis_vec[scan_reg])
                begin
                    if (slot_free)
                    begin
                        pick_valid_next            = 1'b1;
                        pick_word_next.disabled_id = ID_W'(scan_reg);
                        pick_word_next.run_end     = (sent_reg == count_reg - CNT_W'(1));
                        pick_word_next.fault       = FAULT_NONE;
                        sent_next                  = sent_reg + CNT_W'(1);
                        scan_next                  = scan_reg + IDX_W'(1);
                        if (sent_reg == count_reg - CNT_W'(1))
                        begin
                            state_next = S_LOAD;
                        end
                    end
                end
                else
                begin
                    scan_next = scan_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            loaded_reg     <= '0;
            seen_reg       <= '0;
            count_reg      <= '0;
            fault_reg      <= FAULT_NONE;
            step_reg       <= '0;
            scan_reg       <= '0;
            sent_reg       <= '0;
            pick_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            loaded_reg     <= loaded_next;
            seen_reg       <= seen_next;
            count_reg      <= count_next;
            fault_reg      <= fault_next;
            step_reg       <= step_next;
            scan_reg       <= scan_next;
            sent_reg       <= sent_next;
            pick_valid_reg <= pick_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_word_reg <= pick_word_next;
    end

    assign pick_valid = pick_valid_reg;
    assign pick_word  = pick_word_reg;

    // ---------------- ring of cells ----------------
    assign cell_ctrl.clr    = (state_reg == S_START);
    assign cell_ctrl.mul_en = (state_reg == S_RANK);

    for (genvar k = 0; k < MAX_EXPERTS; k++)
    begin : g_cell
        localparam int NXT = (k + 1) % MAX_EXPERTS;
        logic wr_en;
        logic own_vld;

        // words past the last cell are dropped
        assign wr_en   = stat_take && (loaded_reg < CNT_W'(MAX_EXPERTS)) &&
                         (loaded_reg[IDX_W-1:0] == IDX_W'(k));
        assign own_vld = CNT_W'(k) < expert_total_reg;

        ebkps_cell #(
            .IDX (k)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (cell_ctrl),
            .wr_en        (wr_en),
            .wr_num       (norm_num),
            .wr_den       (norm_den),
            .own_vld      (own_vld),
            .prune_count  (count_reg),
            .rot_in       (rot_out[NXT]),
            .rot_out      (rot_out[k]),
            .disable_flag (dis_vec[k])
        );
    end

endmodule

>>> bench/testbench.sv
module testbench;

    import ebkps_pkg::*;

    localparam int MAX_EXP      = 64;
    // Slowest layer: decide, ring pass and output scan, then some slack.
    localparam int DRAIN_CYCLES = 1 + MAX_EXP + 1 + MAX_EXP + 40;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASE_ITEMS  = 8;

    // Register index outside the decoded list; writes must be dropped.
    localparam logic [1:0] REG_SPARE = 2'd3;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [PADDR_W-1:0]  paddr      = '0;
    logic [PDATA_W-1:0]  pwdata     = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                stat_valid = 1'b0;
    logic                stat_ready;
    stat_word_t          stat_word  = '0;
    logic                pick_valid;
    logic                pick_ready = 1'b0;
    pick_word_t          pick_word;

    expert_bottom_k_pruning_selector #(
        .MAX_EXPERTS(MAX_EXP)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .stat_valid(stat_valid),
        .stat_ready(stat_ready),
        .stat_word (stat_word),
        .pick_valid(pick_valid),
        .pick_ready(pick_ready),
        .pick_word (pick_word)
    );

    // ------------------------------------------------------------------
    // Shadow of the block: register copies, loaded statistics and the
    // running load count. Kept in step with every accepted stat word.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]   cfg_total = EXPERT_TOTAL_RST;
    logic [CNT_W-1:0]   cfg_topk  = ROUTER_TOP_K_RST;
    logic [RATIO_W-1:0] cfg_ratio = '0;

    logic [STAT_W-1:0]  sum_mem [MAX_EXP];
    logic [STAT_W-1:0]  hit_mem [MAX_EXP];
    logic [CNT_W-1:0]   load_cnt = '0;

    stat_word_t stat_backlog [$];   // words waiting to be sent
    pick_word_t pick_due_q   [$];   // pick words still owed by the block

    int  mismatch_cnt = 0;
    int  cycle_cnt    = 0;
    int  send_gap     = 0;
    int  pick_stall   = 0;
    bit  calm         = 1'b0;       // no idling on either side while set
    pick_word_t due_pick;

    // Strictly lower importance of expert a against expert b, by exact
    // cross-multiplication; a zero hit count means importance zero.
    function automatic bit weaker(int a, int b);
        logic [63:0] na, da, nb, db;
        na = (hit_mem[a] != 0) ? 64'(sum_mem[a]) : 64'd0;
        da = (hit_mem[a] != 0) ? 64'(hit_mem[a]) : 64'd1;
        nb = (hit_mem[b] != 0) ? 64'(sum_mem[b]) : 64'd0;
        db = (hit_mem[b] != 0) ? 64'(hit_mem[b]) : 64'd1;
        return (na * db) < (nb * da);
    endfunction

    function automatic void owe_fault(logic [FAULT_W-1:0] code);
        pick_due_q.insert(pick_due_q.size(),
                          pick_word_t'{disabled_id: '0, run_end: 1'b1, fault: code});
    endfunction

    // Store the word, and on the final word of a layer work out every pick
    // word the block owes for it.
    function automatic void predict_picks(stat_word_t w);
        int n, e, prune, cap, rank, sent;
        if (load_cnt < MAX_EXP)
        begin
            sum_mem[load_cnt] = w.weighted_sum;
            hit_mem[load_cnt] = w.hit_count;
        end
        if (load_cnt != COUNT_SAT)
            load_cnt = load_cnt + 1'b1;
        if (!w.final_expert)
            return;

        n        = int'(load_cnt);
        load_cnt = '0;
        e        = int'(cfg_total);

        // count check takes priority over everything else
        if (e == 0 || e > MAX_EXP || n != e)
        begin
            owe_fault(FAULT_MISMATCH);
            return;
        end

        prune = (e * int'(cfg_ratio)) >>> 16;
        cap   = (int'(cfg_topk) >= e) ? 0 : e - int'(cfg_topk);
        if (prune > cap)
            prune = cap;
        if (prune == 0)
        begin
            owe_fault(FAULT_ZERO_PRUNE);
            return;
        end

        // Ranks form a strict order (ties to lower id), so exactly `prune`
        // experts fall below it; the last of those carries run_end.
        sent = 0;
        for (int i = 0; i < e; i++)
        begin
            rank = 0;
            for (int j = 0; j < e; j++)
            begin
                if (j != i && (weaker(j, i) || (!weaker(i, j) && j < i)))
                    rank++;
            end
            if (rank < prune)
            begin
                pick_due_q.insert(pick_due_q.size(),
                                  pick_word_t'{disabled_id: ID_W'(i),
                                               run_end: (sent == prune - 1),
                                               fault: FAULT_NONE});
                sent++;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        while (cycle_cnt < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stat word driver. Holds a word until it is taken, then draws an idle
    // gap before offering the next one from the backlog.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stat_valid && stat_ready)
            begin
                predict_picks(stat_word);
                send_gap = calm ? 0 : $urandom_range(0, 6);
            end
            if (!stat_valid || stat_ready)
            begin
                if (send_gap == 0 && stat_backlog.size() != 0)
                begin
                    stat_word  <= stat_backlog.pop_front();
                    stat_valid <= 1'b1;
                end
                else
                begin
                    stat_valid <= 1'b0;
                    if (send_gap != 0)
                        send_gap--;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pick word monitor. Each word taken is checked against the oldest one
    // owed; after each word the receiver stalls for a drawn number of
    // cycles.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pick_valid && pick_ready)
            begin
                if (pick_due_q.size() == 0)
                begin
                    mismatch_cnt++;
                    $display("%0t: unexpected pick word: expected none, got id=%0d end=%0b fault=%0d",
                             $time, pick_word.disabled_id, pick_word.run_end,
                             pick_word.fault);
                end
                else
                begin
                    due_pick = pick_due_q.pop_front();
                    if (pick_word.disabled_id !== due_pick.disabled_id ||
                        pick_word.run_end     !== due_pick.run_end ||
                        pick_word.fault       !== due_pick.fault)
                    begin
                        mismatch_cnt++;
                        $display("%0t: pick mismatch: expected id=%0d end=%0b fault=%0d, got id=%0d end=%0b fault=%0d",
                                 $time, due_pick.disabled_id, due_pick.run_end,
                                 due_pick.fault, pick_word.disabled_id,
                                 pick_word.run_end, pick_word.fault);
                    end
                end
                pick_stall = calm ? 0 : $urandom_range(0, 6);
            end
            else if (pick_stall != 0)
                pick_stall--;
            pick_ready <= (pick_stall == 0);
        end
    end

    // ------------------------------------------------------------------
    // Register access: setup cycle, then access cycle; the transfer happens
    // at the edge closing the access cycle, where prdata is also sampled.
    // ------------------------------------------------------------------
    task automatic apb_xfer(input bit wr, input logic [1:0] idx,
                            input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] want);
        logic [PDATA_W-1:0] got;
        apb_xfer(1'b0, idx, '0, got);
        if (got !== want)
        begin
            mismatch_cnt++;
            $display("%0t: register %0d readback: expected %0h, got %0h",
                     $time, idx, want, got);
        end
    endtask

    // Upper pwdata bits are noise; only the register's own width counts.
    task automatic set_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] dummy;
        apb_xfer(1'b1, idx, value, dummy);
        case (idx)
            REG_EXPERT_TOTAL:
            begin
                cfg_total = value[CNT_W-1:0];
                check_reg(idx, PDATA_W'(cfg_total));
            end
            REG_ROUTER_TOP_K:
            begin
                cfg_topk = value[CNT_W-1:0];
                check_reg(idx, PDATA_W'(cfg_topk));
            end
            REG_PRUNE_RATIO:
            begin
                cfg_ratio = value[RATIO_W-1:0];
                check_reg(idx, PDATA_W'(cfg_ratio));
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic set_cfg(input int total, input int topk, input int ratio);
        set_reg(REG_EXPERT_TOTAL, PDATA_W'(total) | ($urandom() & ~32'h7F));
        set_reg(REG_ROUTER_TOP_K, PDATA_W'(topk) | ($urandom() & ~32'h7F));
        set_reg(REG_PRUNE_RATIO, PDATA_W'(ratio) | ($urandom() & ~32'hFFFF));
    endtask

    // Sender holds off until every owed pick word has arrived, then lets
    // the ring and scan run dry before any register is touched. Checked
    // away from the rising edge so the driver's updates have settled.
    task automatic settle();
        while (stat_backlog.size() != 0 || stat_valid || pick_due_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_word(logic [STAT_W-1:0] s, logic [STAT_W-1:0] h, bit fin);
        stat_backlog.insert(stat_backlog.size(),
                            stat_word_t'{weighted_sum: s, hit_count: h, final_expert: fin});
    endfunction

    function automatic logic [STAT_W-1:0] rand_stat();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(0, 3);
            3:       return 32'h8000_0000 | $urandom();
            default: return $urandom();
        endcase
    endfunction

    // One layer of random words; small scaled ratios make plenty of ties.
    function automatic void push_layer(int len);
        int m;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) < 4)
            begin
                m = $urandom_range(1, 4);
                push_word($urandom_range(0, 3) * m, $urandom_range(0, 3) * m, i == len - 1);
            end
            else
                push_word(rand_stat(), rand_stat(), i == len - 1);
        end
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int total, topk, ratio, len, phase_items;
        @(posedge rst_n);

        // reset values of all three registers
        check_reg(REG_EXPERT_TOTAL, PDATA_W'(EXPERT_TOTAL_RST));
        check_reg(REG_ROUTER_TOP_K, PDATA_W'(ROUTER_TOP_K_RST));
        check_reg(REG_PRUNE_RATIO, '0);

        // reset config expects 64 experts: a one-word layer is a mismatch
        push_word(32'd7, 32'd1, 1'b1);
        settle();

        // four experts, prune three: field extremes, zero hits with a
        // non-zero sum, and equal ratios settled by the lower id
        set_cfg(4, 1, 16'hFFFF);
        push_word('0, '0, 1'b0);
        push_word('1, 32'd1, 1'b0);
        push_word('1, '1, 1'b0);
        push_word('0, '1, 1'b1);
        push_word(32'd6, 32'd4, 1'b0);
        push_word(32'd3, 32'd2, 1'b0);
        push_word(32'd9, 32'd6, 1'b0);
        push_word('1, '0, 1'b1);
        // too many, then too few experts
        push_layer(5);
        push_layer(3);
        settle();

        // router_top_k covering every expert leaves nothing to prune;
        // the spare register index must not disturb anything
        set_cfg(2, 2, 16'hFFFF);
        set_reg(REG_SPARE, '1);
        push_layer(2);
        settle();

        // ratio too small to remove a single expert
        set_cfg(2, 1, 1);
        push_layer(2);
        settle();

        // expert_total of zero, then above the cell count
        set_cfg(0, 1, 16'h8000);
        push_layer(1);
        settle();
        set_cfg(8'hFF, 1, 16'h8000);
        push_layer(1);
        settle();

        // largest layer pruned as hard as allowed: 63 picks
        calm = 1'b0;
        set_cfg(MAX_EXP, 1, 16'hFFFF);
        push_layer(MAX_EXP);
        settle();

        // one expert per layer; a longer layer is a mismatch
        set_cfg(1, $urandom_range(0, 1), $urandom_range(0, 16'hFFFF));
        push_layer(3);
        push_layer(1);
        push_layer(1);
        settle();

        for (int p = 0; p < 4; p++)
        begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
                total = $urandom_range(0, 127);
            else
                total = $urandom_range(2, 8);
            topk = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                               : $urandom_range(0, total);
            case ($urandom_range(0, 3))
                0:       ratio = 16'hFFFF;
                1:       ratio = $urandom_range(0, 16'h1FFF);
                default: ratio = $urandom_range(0, 16'hFFFF);
            endcase
            set_cfg(total, topk, ratio);

            // mostly well-formed short layers; some too long or too short
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                if (total >= 1 && total <= 9 && $urandom_range(0, 4) != 0)
                    len = total;
                else
                    len = $urandom_range(1, 9);
                push_layer(len);
                phase_items += len;
            end
            settle();
        end

        if (mismatch_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/ebkps_pkg.sv
rtl/ebkps_cell.sv
rtl/expert_bottom_k_pruning_selector.sv
bench/testbench.sv
